// File: hw/rtl/dwu_pkg.sv
`timescale 1ns / 1ps

package dwu_pkg;

    localparam int GRID_WIDTH  = 32;
    localparam int GRID_HEIGHT = 32;
    localparam int XW          = $clog2(GRID_WIDTH);
    localparam int YW          = $clog2(GRID_HEIGHT);
    localparam int SITES       = GRID_WIDTH * GRID_HEIGHT;
    localparam int AW          = $clog2(SITES);
    localparam int BOND_W      = 6;
    localparam int NDIR_MAX    = 4 + 8;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_MOVE  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_BOND = 2'd1;
    localparam logic [1:0] ST_NO_DIR  = 2'd2;
    localparam logic [1:0] ST_ILLEGAL = 2'd3;

    localparam logic [2:0] REG_EXT_DX = 3'd0;
    localparam logic [2:0] REG_EXT_DY = 3'd1;
    localparam logic [2:0] REG_W_SS   = 3'd2;
    localparam logic [2:0] REG_W_SE   = 3'd3;
    localparam logic [2:0] REG_W_ES   = 3'd4;
    localparam logic [2:0] REG_W_EE   = 3'd5;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [4:0]  start_x;
        logic [4:0]  start_y;
        logic [15:0] rand_fraction;
        logic [4:0]  bin_index;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic        worm_closed;
        logic        worm_active;
        logic [4:0]  head_x_out;
        logic [4:0]  head_y_out;
        logic [31:0] bin_count;
    } t_out;

    // Bond store word at reset: the +x bond on odd columns.
    function automatic logic [BOND_W-1:0] reset_word(logic [AW-1:0] a);
        logic [XW-1:0] x;
        x = a[XW-1:0];
        return {{(BOND_W-1){1'b0}}, x[0]};
    endfunction

    // Wrap a coordinate plus a small signed offset into 0..n-1.
    function automatic logic [7:0] wrap_c(logic [7:0] c, logic signed [4:0] d,
                                          logic [8:0] n);
        logic signed [10:0] s;
        s = $signed({3'b0, c}) + 11'(d);
        if (s < 0) s = s + $signed({2'b0, n});
        else if (s >= $signed({2'b0, n})) s = s - $signed({2'b0, n});
        return s[7:0];
    endfunction

endpackage

// File: hw/rtl/dwu_stream_if.sv
`timescale 1ns / 1ps

interface dwu_stream_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// File: hw/rtl/dwu_ram.sv
`timescale 1ns / 1ps

module dwu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: hw/rtl/dwu_dir_table.sv
`timescale 1ns / 1ps

module dwu_dir_table (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_we,
    input  logic [2:0]        i_idx,
    input  logic [3:0]        i_ext_dx,
    input  logic [3:0]        i_ext_dy,
    input  logic [3:0]        i_dir,
    output logic signed [4:0] o_dx,
    output logic signed [4:0] o_dy,
    output logic [3:0]        o_ndir
);
    import dwu_pkg::*;

    logic signed [4:0] r_e, r_f, e, f;

    // Extended offset registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e <= 5'sd1;
            r_f <= 5'sd1;
        end else if (i_we) begin
            if (i_idx == REG_EXT_DX) r_e <= 5'($signed(i_ext_dx));
            if (i_idx == REG_EXT_DY) r_f <= 5'($signed(i_ext_dy));
        end
    end

    assign e = r_e;
    assign f = r_f;

    // Offset of the selected direction.
    always_comb begin
        logic swap;
        swap = (e != f) && (e == 0 || f == 0);
        o_ndir = (e == f || e == 0 || f == 0) ? 4'd8 : 4'd12;
        case (i_dir)
            4'd0:    begin o_dx = 5'sd1;  o_dy = 5'sd0;  end
            4'd1:    begin o_dx = -5'sd1; o_dy = 5'sd0;  end
            4'd2:    begin o_dx = 5'sd0;  o_dy = 5'sd1;  end
            4'd3:    begin o_dx = 5'sd0;  o_dy = -5'sd1; end
            4'd4:    begin o_dx = e;      o_dy = f;      end
            4'd5:    begin o_dx = -e;     o_dy = -f;     end
            4'd6:    begin o_dx = swap ? f : -e;  o_dy = swap ? e : f;   end
            4'd7:    begin o_dx = swap ? -f : e;  o_dy = swap ? -e : -f; end
            4'd8:    begin o_dx = f;      o_dy = e;      end
            4'd9:    begin o_dx = -f;     o_dy = -e;     end
            4'd10:   begin o_dx = -f;     o_dy = e;      end
            default: begin o_dx = f;      o_dy = -e;     end
        endcase
    end
endmodule

// File: hw/rtl/dimer_worm_update_top.sv
`timescale 1ns / 1ps

// Worm Monte Carlo engine for close-packed dimers on a periodic 32 x 32 grid.
// Items are taken one at a time; the input is not ready while an item is in
// work or while its result waits. A read or a rejected command offers its
// result in the cycle after it is taken. A start scans the start site one
// direction at a time, each a read of the bond word and a test of its bit.
// A move weighs the candidate directions one at a time (up to 11), then
// checks whether it lands on the tail. If not, it scans the landing site
// in the same way and places the new bond with a read and a write of its
// word. The single bond memory port makes these steps run one after
// another. After reset, a clearing pass writes the columnar state into all
// 1024 bond words, one per cycle, before the first item is accepted.
module dimer_worm_update_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [15:0]          i_cfg_data,
    dwu_stream_if.sink           in_if,
    dwu_stream_if.source         out_if
);
    import dwu_pkg::*;

    typedef enum logic [10:0] {
        S_INIT  = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_FB_RD = 11'b00000000100,
        S_FB_CK = 11'b00000001000,
        S_CHOOSE= 11'b00000010000,
        S_LAND  = 11'b00000100000,
        S_PUT_RD= 11'b00001000000,
        S_PUT_WR= 11'b00010000000,
        S_CLR_RD= 11'b00100000000,
        S_CLR_WR= 11'b01000000000,
        S_OUT   = 11'b10000000000
    } t_state;

    t_state r_state, n_state;
    t_in in_d;
    t_out r_out, n_out;

    logic [15:0] r_w_ss, r_w_se, r_w_es, r_w_ee;
    logic [AW-1:0] r_init, n_init;
    logic [XW-1:0] r_hx, n_hx, r_tx, n_tx, r_nx, n_nx, r_sx, n_sx;
    logic [YW-1:0] r_hy, n_hy, r_ty, n_ty, r_ny, n_ny, r_sy, n_sy;
    logic [3:0] r_din, n_din, r_d, n_d, r_dout, n_dout;
    logic r_active, n_active, r_mode, n_mode;
    logic [31:0] r_cum, n_cum;
    logic [15:0] r_rand, n_rand;
    logic [31:0] r_hits [GRID_WIDTH];
    logic r_hit_we, n_hit_we;
    logic [XW-1:0] r_hit_b, n_hit_b;

    logic signed [4:0] dx, dy;
    logic [3:0] ndir, dir_sel;
    logic ram_we;
    logic [AW-1:0] ram_wa, ram_ra;
    logic [BOND_W-1:0] ram_wd, ram_rd;

    assign in_d = t_in'(in_if.data);
    assign in_if.ready = (r_state == S_IDLE);
    assign out_if.valid = (r_state == S_OUT);
    assign out_if.data = r_out;

    dwu_dir_table u_dir (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_we(i_cfg_we), .i_idx(i_cfg_idx),
        .i_ext_dx(i_cfg_data[3:0]), .i_ext_dy(i_cfg_data[3:0]),
        .i_dir(dir_sel), .o_dx(dx), .o_dy(dy), .o_ndir(ndir)
    );

    dwu_ram #(.WIDTH(BOND_W), .DEPTH(SITES)) u_bonds (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_wa), .i_wdata(ram_wd),
        .i_raddr(ram_ra), .o_rdata(ram_rd)
    );

    // Weight registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_ss <= 16'd9362; r_w_se <= 16'd9362;
            r_w_es <= 16'd9362; r_w_ee <= 16'd9362;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_W_SS: r_w_ss <= i_cfg_data;
                REG_W_SE: r_w_se <= i_cfg_data;
                REG_W_ES: r_w_es <= i_cfg_data;
                REG_W_EE: r_w_ee <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Site that holds the bond of direction d seen from (sx, sy).
    logic [XW-1:0] wx;
    logic [YW-1:0] wy;
    logic [AW-1:0] bond_addr;
    logic [XW-1:0] bx;
    logic [YW-1:0] by;
    logic [15:0] wsel;
    always_comb begin
        wx = XW'(wrap_c(8'(r_sx), dx, 9'(GRID_WIDTH)));
        wy = YW'(wrap_c(8'(r_sy), dy, 9'(GRID_HEIGHT)));
        bx = r_d[0] ? wx : r_sx;
        by = r_d[0] ? wy : r_sy;
        bond_addr = {by, bx};
        if (r_din < 4'd4) wsel = (r_d < 4'd4) ? r_w_ss : r_w_se;
        else              wsel = (r_d < 4'd4) ? r_w_es : r_w_ee;
    end

    assign dir_sel = r_d;

    // Sequencer: the direction unit and memory port are shared by all steps.
    always_comb begin
        logic [2:0] bit_i;
        logic [BOND_W-1:0] word;
        logic [32:0] sum;
        n_state = r_state; n_out = r_out; n_init = r_init;
        n_hx = r_hx; n_hy = r_hy; n_tx = r_tx; n_ty = r_ty;
        n_nx = r_nx; n_ny = r_ny; n_sx = r_sx; n_sy = r_sy;
        n_din = r_din; n_d = r_d; n_dout = r_dout; n_active = r_active;
        n_mode = r_mode; n_cum = r_cum; n_rand = r_rand;
        n_hit_we = 1'b0; n_hit_b = r_hit_b;
        ram_we = 1'b0; ram_wa = bond_addr; ram_wd = '0; ram_ra = bond_addr;
        bit_i = r_d[3:1];
        word = ram_rd;
        sum = {1'b0, r_cum} + {17'b0, wsel};
        unique case (r_state)
            S_INIT: begin
                ram_we = 1'b1; ram_wa = r_init; ram_wd = reset_word(r_init);
                n_init = r_init + 1'b1;
                if (r_init == AW'(SITES - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_if.valid) begin
                    n_out = '0;
                    n_rand = in_d.rand_fraction;
                    if (in_d.cmd == CMD_START && !r_active) begin
                        n_sx = XW'(in_d.start_x); n_sy = YW'(in_d.start_y);
                        n_d = 4'd0; n_mode = 1'b0; n_state = S_FB_RD;
                    end else if (in_d.cmd == CMD_MOVE && r_active) begin
                        n_sx = r_hx; n_sy = r_hy;
                        n_d = (r_din == 4'd0) ? 4'd1 : 4'd0;
                        n_cum = '0; n_state = S_CHOOSE;
                    end else if (in_d.cmd == CMD_READ) begin
                        n_out.bin_count = r_hits[XW'(in_d.bin_index)];
                        n_out.worm_active = r_active;
                        n_out.head_x_out = r_active ? 5'(r_hx) : 5'd0;
                        n_out.head_y_out = r_active ? 5'(r_hy) : 5'd0;
                        n_state = S_OUT;
                    end else begin
                        n_out.status = ST_ILLEGAL;
                        n_out.worm_active = r_active;
                        n_out.head_x_out = r_active ? 5'(r_hx) : 5'd0;
                        n_out.head_y_out = r_active ? 5'(r_hy) : 5'd0;
                        n_state = S_OUT;
                    end
                end
            end
            // First bond scan: read one word, then test its bit.
            S_FB_RD: n_state = S_FB_CK;
            S_FB_CK: begin
                if (word[bit_i]) begin
                    // Remove the bond that was found.
                    ram_we = 1'b1;
                    word[bit_i] = 1'b0;
                    ram_wd = word;
                    n_out.worm_active = 1'b1;
                    if (!r_mode) begin
                        n_hx = r_sx; n_hy = r_sy; n_tx = wx; n_ty = wy;
                        n_din = r_d; n_active = 1'b1;
                        n_out.head_x_out = 5'(r_sx); n_out.head_y_out = 5'(r_sy);
                        n_state = S_OUT;
                    end else begin
                        n_hx = wx; n_hy = wy; n_din = r_d ^ 4'd1;
                        n_out.head_x_out = 5'(wx); n_out.head_y_out = 5'(wy);
                        if (wy == r_ty) begin
                            n_hit_we = 1'b1; n_hit_b = r_tx - wx;
                        end
                        if (r_d == (r_dout ^ 4'd1)) begin
                            // The landing bond is the chosen bond itself, so placing
                            // it and removing it leave it cleared.
                            n_state = S_OUT;
                        end else begin
                            // Now place the chosen bond from the old head.
                            n_sx = r_hx; n_sy = r_hy; n_d = r_dout; n_state = S_CLR_RD;
                        end
                    end
                end else if (r_d == ndir - 4'd1) begin
                    n_out.status = r_mode ? ST_NO_DIR : ST_NO_BOND;
                    n_out.worm_active = r_active;
                    n_out.head_x_out = r_active ? 5'(r_hx) : 5'd0;
                    n_out.head_y_out = r_active ? 5'(r_hy) : 5'd0;
                    n_state = S_OUT;
                end else begin
                    n_d = r_d + 4'd1; n_state = S_FB_RD;
                end
            end
            // Running weight sum over candidate directions.
            S_CHOOSE: begin
                n_cum = sum[31:0];
                if (sum[31:0] >= {16'b0, r_rand}) begin
                    n_dout = r_d; n_nx = wx; n_ny = wy; n_state = S_LAND;
                end else if (r_d >= ndir - 4'd1 ||
                             (r_d == ndir - 4'd2 && r_din == ndir - 4'd1)) begin
                    n_out.status = ST_NO_DIR; n_out.worm_active = 1'b1;
                    n_out.head_x_out = 5'(r_hx); n_out.head_y_out = 5'(r_hy);
                    n_state = S_OUT;
                end else begin
                    n_d = (r_d + 4'd1 == r_din) ? r_d + 4'd2 : r_d + 4'd1;
                end
            end
            S_LAND: begin
                if (r_nx == r_tx && r_ny == r_ty) begin
                    n_active = 1'b0; n_out.worm_closed = 1'b1;
                    n_d = r_dout; n_mode = 1'b0; n_state = S_PUT_RD;
                end else begin
                    n_sx = r_nx; n_sy = r_ny; n_d = 4'd0; n_mode = 1'b1;
                    n_state = S_FB_RD;
                end
            end
            // Place the chosen bond after the landing bond has been removed.
            S_CLR_RD: n_state = S_CLR_WR;
            S_CLR_WR: begin
                ram_we = 1'b1;
                word[bit_i] = 1'b1;
                ram_wd = word;
                n_state = S_OUT;
            end
            // Place the closing bond.
            S_PUT_RD: n_state = S_PUT_WR;
            S_PUT_WR: begin
                ram_we = 1'b1;
                word[bit_i] = 1'b1;
                ram_wd = word;
                n_out.worm_active = 1'b0;
                n_state = S_OUT;
            end
            S_OUT: if (out_if.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control and payload registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT; r_init <= '0; r_active <= 1'b0;
            r_hx <= '0; r_hy <= '0; r_tx <= '0; r_ty <= '0; r_din <= '0;
            r_hit_we <= 1'b0;
            for (int i = 0; i < GRID_WIDTH; i++) r_hits[i] <= '0;
        end else begin
            r_state <= n_state; r_init <= n_init; r_active <= n_active;
            r_hx <= n_hx; r_hy <= n_hy; r_tx <= n_tx; r_ty <= n_ty;
            r_din <= n_din; r_hit_we <= n_hit_we;
            if (r_hit_we && r_hits[r_hit_b] != 32'hFFFF_FFFF)
                r_hits[r_hit_b] <= r_hits[r_hit_b] + 32'd1;
        end
        r_out <= n_out; r_nx <= n_nx; r_ny <= n_ny; r_sx <= n_sx; r_sy <= n_sy;
        r_d <= n_d; r_dout <= n_dout; r_mode <= n_mode; r_cum <= n_cum;
        r_rand <= n_rand; r_hit_b <= n_hit_b;
    end
endmodule

// File: test/tb_dimer_worm_update_top.sv
`timescale 1ns / 1ps

module tb_dimer_worm_update_top;
    import dwu_pkg::*;

    localparam int WATCHDOG_LIMIT = 6000;
    localparam int SETTLE_CYCLES  = 64;
    localparam int RANDOM_PER_SET = 160;

    typedef struct {
        t_in  item;
        bit   typed;
        t_out result;
    } t_vector;

    typedef struct {
        int dx;
        int dy;
        int w[4];
    } t_setting;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;

    dwu_stream_if #(.W($bits(t_in)))  in_if();
    dwu_stream_if #(.W($bits(t_out))) out_if();

    dimer_worm_update_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .in_if      (in_if),
        .out_if     (out_if)
    );

    // Shadow copy of the lattice, the worm and the distance histogram.
    bit [5:0]  lattice[SITES];
    int        worm_hx, worm_hy, worm_tx, worm_ty, worm_in_dir;
    bit        worm_open;
    bit [31:0] dist_hist[GRID_WIDTH];
    int        ext_x, ext_y;
    bit [15:0] jump_w[4];
    int        step_x[12], step_y[12];
    int        dir_count;

    t_out      pending_results[$];
    bit        failed;
    int        idle_cycles;
    int        burst_left;
    int        stall_mode;
    int        stall_timer;

    // Clock.
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic int wrap_coord(int c, int d, int n);
        return (c + d + 8 * n) % n;
    endfunction

    // Direction table built from the extended offset.
    function automatic void set_step(int i, int x, int y);
        step_x[i] = x;
        step_y[i] = y;
    endfunction

    function automatic void rebuild_steps();
        set_step(0, 1, 0);
        set_step(1, -1, 0);
        set_step(2, 0, 1);
        set_step(3, 0, -1);
        set_step(4, ext_x, ext_y);
        set_step(5, -ext_x, -ext_y);
        if (ext_x != ext_y && (ext_x == 0 || ext_y == 0)) begin
            set_step(6, ext_y, ext_x);
            set_step(7, -ext_y, -ext_x);
        end else begin
            set_step(6, -ext_x, ext_y);
            set_step(7, ext_x, -ext_y);
        end
        if (ext_x == ext_y || ext_x == 0 || ext_y == 0) begin
            dir_count = 8;
        end else begin
            set_step(8, ext_y, ext_x);
            set_step(9, -ext_y, -ext_x);
            set_step(10, -ext_y, ext_x);
            set_step(11, ext_y, -ext_x);
            dir_count = 12;
        end
    endfunction

    // Odd directions are stored at the neighbor site, under the even bit.
    function automatic int bond_addr(int x, int y, int d);
        int sx;
        int sy;
        sx = x;
        sy = y;
        if (d % 2 == 1) begin
            sx = wrap_coord(x, step_x[d], GRID_WIDTH);
            sy = wrap_coord(y, step_y[d], GRID_HEIGHT);
        end
        return sy * GRID_WIDTH + sx;
    endfunction

    function automatic bit bond_at(int x, int y, int d);
        return lattice[bond_addr(x, y, d)][d / 2];
    endfunction

    function automatic void bond_set(int x, int y, int d, bit v);
        lattice[bond_addr(x, y, d)][d / 2] = v;
    endfunction

    function automatic int first_bond_dir(int x, int y);
        for (int d = 0; d < dir_count; d++)
            if (bond_at(x, y, d))
                return d;
        return -1;
    endfunction

    function automatic bit [15:0] jump_weight(int din, int dout);
        return jump_w[(din >= 4 ? 2 : 0) + (dout >= 4 ? 1 : 0)];
    endfunction

    function automatic int pick_out_dir(int din, bit [15:0] frac);
        bit [31:0] sum;
        sum = 0;
        for (int d = 0; d < dir_count; d++) begin
            if (d == din)
                continue;
            sum += jump_weight(din, d);
            if (sum >= frac)
                return d;
        end
        return -1;
    endfunction

    function automatic void reset_model();
        for (int a = 0; a < SITES; a++)
            lattice[a] = {5'b0, a[0]};
        worm_hx = 0;
        worm_hy = 0;
        worm_tx = 0;
        worm_ty = 0;
        worm_in_dir = 0;
        worm_open = 1'b0;
        for (int b = 0; b < GRID_WIDTH; b++)
            dist_hist[b] = 0;
        ext_x = 1;
        ext_y = 1;
        for (int k = 0; k < 4; k++)
            jump_w[k] = 16'd9362;
        rebuild_steps();
    endfunction

    // Advance the shadow worm by one transaction and return its result.
    function automatic t_out worm_step(t_in it);
        t_out r;
        int   ex;
        int   dout;
        int   nx;
        int   ny;
        int   b;
        r = '0;
        if (it.cmd == CMD_START && !worm_open) begin
            ex = first_bond_dir(it.start_x, it.start_y);
            if (ex < 0) begin
                r.status = ST_NO_BOND;
            end else begin
                worm_hx = it.start_x;
                worm_hy = it.start_y;
                worm_tx = wrap_coord(worm_hx, step_x[ex], GRID_WIDTH);
                worm_ty = wrap_coord(worm_hy, step_y[ex], GRID_HEIGHT);
                worm_in_dir = ex;
                bond_set(worm_hx, worm_hy, ex, 1'b0);
                worm_open = 1'b1;
            end
        end else if (it.cmd == CMD_MOVE && worm_open) begin
            dout = pick_out_dir(worm_in_dir, it.rand_fraction);
            if (dout < 0) begin
                r.status = ST_NO_DIR;
            end else begin
                nx = wrap_coord(worm_hx, step_x[dout], GRID_WIDTH);
                ny = wrap_coord(worm_hy, step_y[dout], GRID_HEIGHT);
                if (nx == worm_tx && ny == worm_ty) begin
                    bond_set(worm_hx, worm_hy, dout, 1'b1);
                    worm_open = 1'b0;
                    r.worm_closed = 1'b1;
                end else begin
                    ex = first_bond_dir(nx, ny);
                    if (ex < 0) begin
                        r.status = ST_NO_DIR;
                    end else begin
                        bond_set(worm_hx, worm_hy, dout, 1'b1);
                        bond_set(nx, ny, ex, 1'b0);
                        worm_hx = wrap_coord(nx, step_x[ex], GRID_WIDTH);
                        worm_hy = wrap_coord(ny, step_y[ex], GRID_HEIGHT);
                        worm_in_dir = ex ^ 1;
                        if (worm_ty == worm_hy) begin
                            b = (worm_tx + GRID_WIDTH - worm_hx) % GRID_WIDTH;
                            if (dist_hist[b] != 32'hFFFF_FFFF)
                                dist_hist[b]++;
                        end
                    end
                end
            end
        end else if (it.cmd == CMD_READ) begin
            r.bin_count = dist_hist[it.bin_index];
        end else begin
            r.status = ST_ILLEGAL;
        end
        r.worm_active = worm_open;
        r.head_x_out  = worm_open ? worm_hx[4:0] : 5'd0;
        r.head_y_out  = worm_open ? worm_hy[4:0] : 5'd0;
        return r;
    endfunction

    // Present one transaction and wait until the block takes it.
    task automatic send_item(t_in it, bit typed, t_out typed_result);
        t_out r;
        in_if.valid <= 1'b1;
        in_if.data  <= it;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        r = worm_step(it);
        pending_results.push_back(typed ? typed_result : r);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 5);
        end
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        case (idx)
            REG_EXT_DX: ext_x = $signed(value[3:0]);
            REG_EXT_DY: ext_y = $signed(value[3:0]);
            REG_W_SS:   jump_w[0] = value;
            REG_W_SE:   jump_w[1] = value;
            REG_W_ES:   jump_w[2] = value;
            REG_W_EE:   jump_w[3] = value;
            default: ;
        endcase
        rebuild_steps();
        i_cfg_we <= 1'b0;
    endtask

    // Drain every outstanding result, let the block settle, then reprogram it.
    task automatic apply_setting(t_setting s);
        in_if.valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(REG_EXT_DX, 16'(s.dx));
        write_reg(REG_EXT_DY, 16'(s.dy));
        write_reg(REG_W_SS, 16'(s.w[0]));
        write_reg(REG_W_SE, 16'(s.w[1]));
        write_reg(REG_W_ES, 16'(s.w[2]));
        write_reg(REG_W_EE, 16'(s.w[3]));
        @(posedge i_clk);
    endtask

    function automatic t_in make_item(logic [1:0] cmd, int x, int y, int frac, int bin);
        t_in it;
        it.cmd           = cmd;
        it.start_x       = 5'(x);
        it.start_y       = 5'(y);
        it.rand_fraction = 16'(frac);
        it.bin_index     = 5'(bin);
        return it;
    endfunction

    function automatic t_out make_result(logic [1:0] status, bit active, int hx, int hy);
        t_out r;
        r = '0;
        r.status      = status;
        r.worm_active = active;
        r.head_x_out  = 5'(hx);
        r.head_y_out  = 5'(hy);
        return r;
    endfunction

    // Random transaction, mostly well-formed worms with some noise.
    function automatic t_in random_item();
        t_in it;
        int  pick;
        it   = make_item(CMD_READ, $urandom_range(0, 31), $urandom_range(0, 31),
                         $urandom_range(0, 65535), $urandom_range(0, 31));
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 7))
            0:       it.rand_fraction = 16'd0;
            1:       it.rand_fraction = 16'hFFFF;
            default: it.rand_fraction = 16'($urandom_range(0, 65535));
        endcase
        if (pick < 4)
            it.cmd = 2'd3;
        else if (pick < 12)
            it.cmd = CMD_READ;
        else if (pick < 16)
            it.cmd = worm_open ? CMD_START : CMD_MOVE;
        else
            it.cmd = worm_open ? CMD_MOVE : CMD_START;
        return it;
    endfunction

    // Result checking and receiver stall pattern.
    always @(posedge i_clk) begin
        t_out want;
        t_out got;
        if (out_if.valid && out_if.ready) begin
            got = out_if.data;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                failed = 1'b1;
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, got.status);
                    failed = 1'b1;
                end
                if (got.worm_closed !== want.worm_closed) begin
                    $display("%0t: worm_closed expected %0d actual %0d",
                             $time, want.worm_closed, got.worm_closed);
                    failed = 1'b1;
                end
                if (got.worm_active !== want.worm_active) begin
                    $display("%0t: worm_active expected %0d actual %0d",
                             $time, want.worm_active, got.worm_active);
                    failed = 1'b1;
                end
                if (got.head_x_out !== want.head_x_out) begin
                    $display("%0t: head_x_out expected %0d actual %0d",
                             $time, want.head_x_out, got.head_x_out);
                    failed = 1'b1;
                end
                if (got.head_y_out !== want.head_y_out) begin
                    $display("%0t: head_y_out expected %0d actual %0d",
                             $time, want.head_y_out, got.head_y_out);
                    failed = 1'b1;
                end
                if (got.bin_count !== want.bin_count) begin
                    $display("%0t: bin_count expected %0d actual %0d",
                             $time, want.bin_count, got.bin_count);
                    failed = 1'b1;
                end
            end
        end
        if (stall_timer == 0) begin
            stall_mode  = $urandom_range(0, 3);
            stall_timer = $urandom_range(20, 120);
        end else begin
            stall_timer--;
        end
        out_if.ready <= (stall_mode == 0) || ($urandom_range(0, stall_mode) == 0);
    end

    // Watchdog on cycles without any transaction.
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        t_vector  vectors[$];
        t_setting settings[$];
        t_vector  v;
        t_out     none;

        failed       = 1'b0;
        idle_cycles  = 0;
        burst_left   = 0;
        stall_mode   = 0;
        stall_timer  = 0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = REG_EXT_DX;
        i_cfg_data   = '0;
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        out_if.ready = 1'b0;
        none         = '0;
        reset_model();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed vectors on the columnar start state.
        v.typed = 1'b1;
        v.item = make_item(CMD_READ, 0, 0, 0, 0);
        v.result = make_result(ST_OK, 0, 0, 0);
        vectors.push_back(v);
        v.item = make_item(CMD_READ, 31, 31, 65535, 31);
        vectors.push_back(v);
        v.item = make_item(CMD_MOVE, 0, 0, 0, 0);
        v.result = make_result(ST_ILLEGAL, 0, 0, 0);
        vectors.push_back(v);
        v.item = make_item(2'd3, 31, 31, 65535, 31);
        vectors.push_back(v);
        v.item = make_item(CMD_START, 0, 0, 0, 0);
        v.result = make_result(ST_OK, 1, 0, 0);
        vectors.push_back(v);
        v.item = make_item(CMD_START, 31, 31, 0, 0);
        v.result = make_result(ST_ILLEGAL, 1, 0, 0);
        vectors.push_back(v);
        v.typed = 1'b0;
        v.result = none;
        v.item = make_item(CMD_MOVE, 0, 0, 65535, 0);
        vectors.push_back(v);
        v.item = make_item(CMD_MOVE, 0, 0, 0, 0);
        vectors.push_back(v);
        for (int k = 0; k < 8; k++) begin
            v.item = make_item(CMD_MOVE, 31, 31, 9362 * (k % 7) + 1, 0);
            vectors.push_back(v);
        end
        for (int k = 0; k < 4; k++) begin
            v.item = make_item(CMD_READ, 0, 0, 0, k * 10 + 1);
            vectors.push_back(v);
        end
        v.item = make_item(CMD_START, 31, 31, 0, 0);
        vectors.push_back(v);
        v.item = make_item(CMD_MOVE, 31, 0, 40000, 0);
        vectors.push_back(v);
        foreach (vectors[i])
            send_item(vectors[i].item, vectors[i].typed, vectors[i].result);

        // Register settings, with the extremes of every weight field.
        settings.push_back('{2, 1, '{5000, 6000, 7000, 8000}});
        settings.push_back('{-4, 4, '{65535, 0, 0, 65535}});
        settings.push_back('{4, -4, '{0, 0, 0, 0}});
        settings.push_back('{0, 3, '{3000, 12000, 3000, 12000}});
        settings.push_back('{-1, 0, '{0, 65535, 65535, 0}});
        settings.push_back('{3, -2, '{9000, 9000, 9000, 9000}});
        settings.push_back('{1, 1, '{9362, 9362, 9362, 9362}});

        foreach (settings[s]) begin
            apply_setting(settings[s]);
            for (int n = 0; n < RANDOM_PER_SET; n++)
                send_item(random_item(), 1'b0, none);
        end

        // Wind down and give the verdict.
        in_if.valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (!failed)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
